### rtl/rlpc_pkg.sv
// rlpc_pkg: types, codes and helpers shared by the run-length pattern compressor
// no dependencies
`timescale 1ns / 1ps

package rlpc_pkg;

  localparam int unsigned MaxChunkDef = 64;
  localparam int unsigned CntW        = 7;
  localparam int unsigned FillW       = 3;
  localparam int unsigned WinDepth    = 4;
  localparam int unsigned PaddrW      = 4;

  localparam logic [1:0] TypeMask  = 2'h3;
  localparam logic [5:0] CountMask = 6'h3F;

  // chunk type, low two bits are the header type field
  typedef enum logic [2:0] {
    KIND_DEF  = 3'd0,
    KIND_ONE  = 3'd1,
    KIND_PAIR = 3'd2,
    KIND_LIT  = 3'd3,
    KIND_NONE = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ACT_REST,
    ACT_ADV,
    ACT_CLOSE
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_SCAN,
    ST_CK_HDR,
    ST_CK_B0,
    ST_CK_B1,
    ST_CK_LIT,
    ST_TERM,
    ST_DONE
  } st_e;

  typedef enum logic [1:0] {
    REG_DEFAULT = 2'd0,
    REG_HDR_EN  = 2'd1,
    REG_TERM_EN = 2'd2
  } reg_e;

  typedef struct packed {
    logic [WinDepth-1:0][7:0] win;
    logic [FillW-1:0]         fill;
    kind_e                    kind;
    logic [CntW-1:0]          cnt;
    logic [15:0]              pair;
  } scan_st_t;

  typedef struct packed {
    act_e            act;
    scan_st_t        nxt;
    logic            rest_nxt;
    logic            lit_we;
    logic [CntW-1:0] lit_addr;
    logic [7:0]      lit_data;
  } step_res_t;

  typedef struct packed {
    logic       byte_vld;
    logic [7:0] data;
    logic       mrk;
    logic       done;
  } push_t;

  typedef struct packed {
    logic byte_ok;
    logic mrk_ok;
  } pk_rdy_t;

  // remove n bytes from the front of the lookahead window
  function automatic scan_st_t drop_front(scan_st_t s, logic [FillW-1:0] n);
    scan_st_t r;
    r = s;
    for (int k = 0; k < WinDepth; k++) begin
      if (k + int'(n) < WinDepth) begin
        r.win[k] = s.win[k + int'(n)];
      end
    end
    r.fill = s.fill - n;
    return r;
  endfunction

endpackage

### rtl/run_length_pattern_compressor.sv
// run_length_pattern_compressor: top level with register port, scan sequencer and literal memory
// depends on rlpc_pkg, rlpc_step, rlpc_pack
`timescale 1ns / 1ps

// Byte stream compressor. Each accepted request carries one data byte and an end flag; the
// results are the compressed bytes that byte releases, up to two per result, with batch_last
// on the last result of the request and output_done on the last result of the stream. A
// request that only extends a run or a literal chunk lets the next one in on the same edge,
// so plain data streams in at one byte per clock while the packer is free. Closing a chunk
// emits its header and payload at one byte per cycle through the packer while it is not
// stalled, reading a literal chunk back from the literal memory; the input stalls meanwhile.
// The end of a stream adds the flush of the open chunk, the optional terminator byte and
// ST_DONE, which clears the stream state. The literal memory needs no clearing pass after reset.
module run_length_pattern_compressor #(
  parameter int unsigned MaxChunk = rlpc_pkg::MaxChunkDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rlpc_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  data_byte_i,
  input  logic                        stream_end_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  byte_a_o,
  output logic [7:0]                  byte_b_o,
  output logic [1:0]                  byte_count_o,
  output logic                        batch_last_o,
  output logic                        output_done_o
);
  import rlpc_pkg::*;

  localparam int unsigned LitAw    = $clog2(MaxChunk);
  localparam int unsigned LitDepth = 2 ** LitAw;

  // configuration
  logic [7:0] dflt_q;
  logic       hdr_en_q;
  logic       term_en_q;
  logic       cfg_we;
  reg_e       reg_idx;

  // stream state
  st_e              st_q, st_d;
  scan_st_t         ss_q, ss_d;
  logic             end_q, end_d;
  logic             started_q, started_d;
  kind_e            ck_kind_q, ck_kind_d;
  logic [CntW-1:0]  ck_cnt_q, ck_cnt_d;
  logic [15:0]      ck_pair_q, ck_pair_d;
  logic             fin_q, fin_d;
  logic [LitAw-1:0] li_q, li_d;
  logic [LitAw-1:0] rd_addr;
  logic [7:0]       rd_q;
  logic [7:0]       lit_mem [LitDepth];

  step_res_t res;
  push_t     push;
  pk_rdy_t   pk_rdy;
  scan_st_t  app_base;
  scan_st_t  app;
  logic      settle;
  logic      in_ok;
  logic      in_acc;
  logic      have_chunk;
  logic      lit_last;
  st_e       after_st;
  logic [7:0] hdr_byte;

  // register port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q    <= 8'h00;
      hdr_en_q  <= 1'b0;
      term_en_q <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_DEFAULT: dflt_q    <= pwdata[7:0];
        REG_HDR_EN:  hdr_en_q  <= pwdata[0];
        REG_TERM_EN: term_en_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEFAULT: prdata = {24'h0, dflt_q};
      REG_HDR_EN:  prdata = {31'h0, hdr_en_q};
      REG_TERM_EN: prdata = {31'h0, term_en_q};
      default:     prdata = 32'h0;
    endcase
  end

  rlpc_step #(
    .MaxChunk(MaxChunk)
  ) u_step (
    .st_i  (ss_q),
    .end_i (end_q),
    .dflt_i(dflt_q),
    .res_o (res)
  );

  rlpc_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .rdy_o        (pk_rdy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_a_o     (byte_a_o),
    .byte_b_o     (byte_b_o),
    .byte_count_o (byte_count_o),
    .batch_last_o (batch_last_o),
    .output_done_o(output_done_o)
  );

  // a decision that leaves the scanner at rest lets the next byte in on the same edge
  assign settle     = (st_q == ST_SCAN) && (res.act != ACT_CLOSE) && res.rest_nxt && !end_q;
  assign have_chunk = (ss_q.kind != KIND_NONE) && (ss_q.cnt != '0);
  assign lit_last   = (CntW'(li_q) == ck_cnt_q - CntW'(1));
  assign after_st   = fin_q ? (term_en_q ? ST_TERM : ST_DONE) : ST_SCAN;
  assign hdr_byte   = {ck_kind_q[1:0] & TypeMask, 6'(ck_cnt_q - CntW'(1)) & CountMask};

  assign app_base = (st_q == ST_IDLE) ? ss_q : res.nxt;
  always_comb begin
    app                           = app_base;
    app.win[app_base.fill[1:0]]   = data_byte_i;
    app.fill                      = app_base.fill + FillW'(1);
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          st_d = (!started_q && hdr_en_q) ? ST_HDR : ST_SCAN;
        end
      end
      ST_HDR: begin
        if (pk_rdy.byte_ok) begin
          st_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (res.act == ACT_CLOSE) begin
          st_d = ST_CK_HDR;
        end else if (res.act == ACT_REST && end_q) begin
          st_d = have_chunk ? ST_CK_HDR : (term_en_q ? ST_TERM : ST_DONE);
        end else if (settle && pk_rdy.mrk_ok) begin
          st_d = in_acc ? ST_SCAN : ST_IDLE;
        end
      end
      ST_CK_HDR: begin
        if (pk_rdy.byte_ok) begin
          case (ck_kind_q)
            KIND_DEF:  st_d = after_st;
            KIND_ONE:  st_d = ST_CK_B1;
            KIND_PAIR: st_d = ST_CK_B0;
            default:   st_d = ST_CK_LIT;
          endcase
        end
      end
      ST_CK_B0: begin
        if (pk_rdy.byte_ok) begin
          st_d = ST_CK_B1;
        end
      end
      ST_CK_B1: begin
        if (pk_rdy.byte_ok) begin
          st_d = after_st;
        end
      end
      ST_CK_LIT: begin
        if (pk_rdy.byte_ok && lit_last) begin
          st_d = after_st;
        end
      end
      ST_TERM: begin
        if (pk_rdy.byte_ok) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (pk_rdy.mrk_ok) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    push     = '0;
    in_ok    = 1'b0;
    rd_addr  = li_q;
    case (st_q)
      ST_IDLE: in_ok = 1'b1;
      ST_HDR: begin
        push.byte_vld = 1'b1;
        push.data     = dflt_q;
      end
      ST_SCAN: begin
        push.mrk = settle;
        in_ok    = settle && pk_rdy.mrk_ok;
      end
      ST_CK_HDR: begin
        push.byte_vld = 1'b1;
        push.data     = hdr_byte;
        rd_addr       = '0;
      end
      ST_CK_B0: begin
        push.byte_vld = 1'b1;
        push.data     = ck_pair_q[15:8];
      end
      ST_CK_B1: begin
        push.byte_vld = 1'b1;
        push.data     = ck_pair_q[7:0];
      end
      ST_CK_LIT: begin
        push.byte_vld = 1'b1;
        push.data     = rd_q;
        rd_addr       = pk_rdy.byte_ok ? li_q + LitAw'(1) : li_q;
      end
      ST_TERM: begin
        push.byte_vld = 1'b1;
        push.data     = 8'h00;
      end
      ST_DONE: begin
        push.mrk  = 1'b1;
        push.done = 1'b1;
      end
      default: ;
    endcase
    in_acc = in_valid_i && in_ok;
  end

  assign in_stall_o = !in_ok;

  // datapath updates
  always_comb begin
    ss_d      = ss_q;
    end_d     = end_q;
    started_d = started_q;
    ck_kind_d = ck_kind_q;
    ck_cnt_d  = ck_cnt_q;
    ck_pair_d = ck_pair_q;
    fin_d     = fin_q;
    li_d      = li_q;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          ss_d      = app;
          end_d     = stream_end_i;
          started_d = 1'b1;
        end
      end
      ST_SCAN: begin
        ss_d = res.nxt;
        if (res.act == ACT_CLOSE) begin
          ck_kind_d = ss_q.kind;
          ck_cnt_d  = ss_q.cnt;
          ck_pair_d = ss_q.pair;
          fin_d     = 1'b0;
        end else if (res.act == ACT_REST && end_q && have_chunk) begin
          // final flush of the open chunk
          ck_kind_d = ss_q.kind;
          ck_cnt_d  = ss_q.cnt;
          ck_pair_d = ss_q.pair;
          fin_d     = 1'b1;
          ss_d.kind = KIND_NONE;
          ss_d.cnt  = '0;
        end else if (res.act == ACT_REST && end_q) begin
          fin_d = 1'b1;
        end
        if (in_acc) begin
          ss_d  = app;
          end_d = stream_end_i;
        end
      end
      ST_CK_HDR: begin
        if (pk_rdy.byte_ok) begin
          li_d = '0;
        end
      end
      ST_CK_LIT: begin
        if (pk_rdy.byte_ok) begin
          li_d = li_q + LitAw'(1);
        end
      end
      ST_DONE: begin
        if (pk_rdy.mrk_ok) begin
          ss_d.fill = '0;
          ss_d.kind = KIND_NONE;
          ss_d.cnt  = '0;
          ss_d.pair = '0;
          started_d = 1'b0;
          end_d     = 1'b0;
          fin_d     = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      ss_q      <= '{win: '0, fill: '0, kind: KIND_NONE, cnt: '0, pair: '0};
      end_q     <= 1'b0;
      started_q <= 1'b0;
      fin_q     <= 1'b0;
      li_q      <= '0;
      ck_kind_q <= KIND_NONE;
      ck_cnt_q  <= '0;
    end else begin
      st_q      <= st_d;
      ss_q      <= ss_d;
      end_q     <= end_d;
      started_q <= started_d;
      fin_q     <= fin_d;
      li_q      <= li_d;
      ck_kind_q <= ck_kind_d;
      ck_cnt_q  <= ck_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ck_pair_q <= ck_pair_d;
  end

  // literal memory: written only while scanning, read back only while a chunk closes,
  // so the two never touch the same entry in one cycle
  always_ff @(posedge clk_i) begin
    if (st_q == ST_SCAN && res.lit_we) begin
      lit_mem[res.lit_addr[LitAw-1:0]] <= res.lit_data;
    end
    rd_q <= lit_mem[rd_addr];
  end

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ss_q.cnt <= CntW'(MaxChunk))
    else $error("chunk count above cap");

  a_lit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CK_LIT |-> CntW'(li_q) < ck_cnt_q)
    else $error("literal readback past chunk end");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && output_done_o |-> batch_last_o)
    else $error("stream end without request end");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != ST_IDLE && st_q != ST_SCAN |-> in_stall_o)
    else $error("request taken while a chunk is emitted");

endmodule

### rtl/rlpc_step.sv
// rlpc_step: one decision of the chunk scanner, purely combinational
// depends on rlpc_pkg
`timescale 1ns / 1ps

module rlpc_step #(
  parameter int unsigned MaxChunk = rlpc_pkg::MaxChunkDef
) (
  input  rlpc_pkg::scan_st_t  st_i,
  input  logic                end_i,
  input  logic [7:0]          dflt_i,
  output rlpc_pkg::step_res_t res_o
);
  import rlpc_pkg::*;

  localparam logic [CntW-1:0] CntCap = CntW'(MaxChunk);

  logic       capped;
  logic       pair_hit;
  logic       def_hit;
  logic       one_hit;
  logic       is_lit;
  logic [7:0] w0;
  logic [7:0] w1;
  logic [7:0] w2;
  logic [7:0] w3;

  function automatic logic at_rest(scan_st_t s, logic e);
    logic r;
    logic cap;
    cap = (s.kind != KIND_NONE) && (s.cnt >= CntCap);
    case (s.kind)
      KIND_DEF, KIND_ONE: r = (s.fill == '0);
      KIND_PAIR:          r = (s.fill < FillW'(2)) && !e;
      default:            r = (s.fill == '0) || ((s.fill < FillW'(4)) && !e);
    endcase
    return r && !cap;
  endfunction

  assign w0 = st_i.win[0];
  assign w1 = st_i.win[1];
  assign w2 = st_i.win[2];
  assign w3 = st_i.win[3];

  assign capped   = (st_i.kind != KIND_NONE) && (st_i.cnt >= CntCap);
  assign pair_hit = (st_i.fill >= FillW'(4)) && (w0 != w1) && (w0 == w2) && (w1 == w3);
  assign def_hit  = (st_i.fill >= FillW'(2)) && (w0 == dflt_i) && (w1 == dflt_i);
  assign one_hit  = (st_i.fill >= FillW'(2)) && (w0 == w1);
  assign is_lit   = (st_i.kind == KIND_LIT);

  always_comb begin
    res_o          = '0;
    res_o.act      = ACT_REST;
    res_o.nxt      = st_i;
    res_o.lit_we   = 1'b0;
    res_o.lit_addr = '0;
    res_o.lit_data = w0;
    if (capped) begin
      res_o.act      = ACT_CLOSE;
      res_o.nxt.kind = KIND_NONE;
      res_o.nxt.cnt  = '0;
    end else begin
      case (st_i.kind)
        KIND_DEF, KIND_ONE: begin
          if (st_i.fill != '0) begin
            if (w0 == st_i.pair[7:0]) begin
              res_o.act     = ACT_ADV;
              res_o.nxt     = drop_front(st_i, FillW'(1));
              res_o.nxt.cnt = st_i.cnt + CntW'(1);
            end else begin
              res_o.act      = ACT_CLOSE;
              res_o.nxt.kind = KIND_NONE;
              res_o.nxt.cnt  = '0;
            end
          end
        end
        KIND_PAIR: begin
          if (st_i.fill < FillW'(2)) begin
            if (end_i) begin
              res_o.act      = ACT_CLOSE;
              res_o.nxt.kind = KIND_NONE;
              res_o.nxt.cnt  = '0;
            end
          end else if (w0 == st_i.pair[15:8] && w1 == st_i.pair[7:0]) begin
            res_o.act     = ACT_ADV;
            res_o.nxt     = drop_front(st_i, FillW'(2));
            res_o.nxt.cnt = st_i.cnt + CntW'(1);
          end else begin
            res_o.act      = ACT_CLOSE;
            res_o.nxt.kind = KIND_NONE;
            res_o.nxt.cnt  = '0;
          end
        end
        default: begin
          if (st_i.fill == '0 || (st_i.fill < FillW'(4) && !end_i)) begin
            res_o.act = ACT_REST;
          end else if (pair_hit || def_hit || one_hit) begin
            // a new run closes an open literal chunk first
            res_o.act = is_lit ? ACT_CLOSE : ACT_ADV;
            if (pair_hit) begin
              res_o.nxt      = drop_front(st_i, FillW'(4));
              res_o.nxt.kind = KIND_PAIR;
              res_o.nxt.pair = {w0, w1};
            end else if (def_hit) begin
              res_o.nxt      = drop_front(st_i, FillW'(2));
              res_o.nxt.kind = KIND_DEF;
              res_o.nxt.pair = {8'h00, dflt_i};
            end else begin
              res_o.nxt      = drop_front(st_i, FillW'(2));
              res_o.nxt.kind = KIND_ONE;
              res_o.nxt.pair = {8'h00, w0};
            end
            res_o.nxt.cnt = CntW'(2);
          end else begin
            res_o.act      = ACT_ADV;
            res_o.lit_we   = 1'b1;
            res_o.lit_addr = is_lit ? st_i.cnt : '0;
            res_o.nxt      = drop_front(st_i, FillW'(1));
            res_o.nxt.kind = KIND_LIT;
            res_o.nxt.cnt  = (is_lit ? st_i.cnt : '0) + CntW'(1);
          end
        end
      endcase
    end
    res_o.rest_nxt = at_rest(res_o.nxt, end_i);
  end

endmodule

### rtl/rlpc_pack.sv
// rlpc_pack: packs emitted bytes up to two per result and holds the output register
// depends on rlpc_pkg
`timescale 1ns / 1ps

module rlpc_pack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rlpc_pkg::push_t   push_i,
  output rlpc_pkg::pk_rdy_t rdy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        byte_a_o,
  output logic [7:0]        byte_b_o,
  output logic [1:0]        byte_count_o,
  output logic              batch_last_o,
  output logic              output_done_o
);
  import rlpc_pkg::*;

  logic [7:0] h0_q, h0_d;
  logic [7:0] h1_q, h1_d;
  logic [1:0] hcnt_q, hcnt_d;
  logic       vld_q, vld_d;
  logic [7:0] a_q, a_d;
  logic [7:0] b_q, b_d;
  logic [1:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  logic       done_q, done_d;
  logic       out_free;
  logic       load;

  assign out_free      = !vld_q || !out_stall_i;
  assign rdy_o.byte_ok = (hcnt_q != 2'd2) || out_free;
  assign rdy_o.mrk_ok  = (hcnt_q == 2'd0) || out_free;

  always_comb begin
    h0_d   = h0_q;
    h1_d   = h1_q;
    hcnt_d = hcnt_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    done_d = done_q;
    load   = 1'b0;
    if (push_i.byte_vld && rdy_o.byte_ok) begin
      case (hcnt_q)
        2'd0: begin
          h0_d   = push_i.data;
          hcnt_d = 2'd1;
        end
        2'd1: begin
          h1_d   = push_i.data;
          hcnt_d = 2'd2;
        end
        default: begin
          // a third byte proves the held pair is not the last of the request
          load   = 1'b1;
          a_d    = h0_q;
          b_d    = h1_q;
          cnt_d  = 2'd2;
          last_d = 1'b0;
          done_d = 1'b0;
          h0_d   = push_i.data;
          hcnt_d = 2'd1;
        end
      endcase
    end else if (push_i.mrk && rdy_o.mrk_ok && hcnt_q != 2'd0) begin
      load   = 1'b1;
      a_d    = h0_q;
      b_d    = (hcnt_q == 2'd2) ? h1_q : 8'h00;
      cnt_d  = hcnt_q;
      last_d = 1'b1;
      done_d = push_i.done;
      hcnt_d = 2'd0;
    end
    vld_d = load ? 1'b1 : (out_stall_i ? vld_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= 2'd0;
      vld_q  <= 1'b0;
    end else begin
      hcnt_q <= hcnt_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h0_q   <= h0_d;
    h1_q   <= h1_d;
    a_q    <= a_d;
    b_q    <= b_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
    done_q <= done_d;
  end

  assign out_valid_o   = vld_q;
  assign byte_a_o      = a_q;
  assign byte_b_o      = b_q;
  assign byte_count_o  = cnt_q;
  assign batch_last_o  = last_q;
  assign output_done_o = done_q;

endmodule
